// ----- hdl/w6ps_pkg.sv -----
// ----------------------------------------------------------------------------
// w6ps_pkg
// Shared constants and controller/datapath interface types for the
// 6k-1 / 6k+1 wheel prime sieve.
// ----------------------------------------------------------------------------
package w6ps_pkg;

   localparam int MAX_NUMBER  = 16384;
   localparam int TABLE_DEPTH = (MAX_NUMBER + 11) / 6;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int WALK_W      = $clog2(8 * TABLE_DEPTH);

   localparam int NUM_W       = 14;
   localparam int QUOT_W      = NUM_W - 2;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_SIX = RECIP_W'(10923);

   typedef enum logic {
      KIND_BUILD = 1'b0,
      KIND_QUERY = 1'b1
   } w6ps_kind_type;

   typedef struct packed {
      logic capture;
      logic fill_write;
      logic outer_first;
      logic outer_inc;
      logic rd_outer;
      logic walk_init;
      logic walk_minus;
      logic strike;
      logic set_built;
      logic q_mul;
      logic q_rd;
      logic rsp_load;
   } w6ps_cmd_type;

   typedef struct packed {
      logic kind_query;
      logic outer_last;
      logic rd_minus;
      logic rd_plus;
      logic walk_end;
      logic more_plus;
      logic out_busy;
   } w6ps_sts_type;

endpackage

// ----- hdl/wheel6_prime_sieve.sv -----
// ----------------------------------------------------------------------------
// wheel6_prime_sieve
// Query: the accepted beat is captured, scaled by 1/6 (Q_MUL), looked up (Q_RD)
//   and loaded as the result (RESP); the next request waits for that load.
// Build: entry-at-a-time fill, then a walk striking multiples of each prime found.
// Reset clears control and the built flag; queries other than 2 and 3 read as
//   not prime until the first build completes.
// ----------------------------------------------------------------------------
module wheel6_prime_sieve (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [13:0] number, [15:14] zero
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] prime_flag, [1] table_ready, [7:2] zero
);

   w6ps_pkg::w6ps_cmd_type cmd;
   w6ps_pkg::w6ps_sts_type sts;

   w6ps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   w6ps_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- hdl/w6ps_ram.sv -----
// ----------------------------------------------------------------------------
// w6ps_ram
// Single-bit flag memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module w6ps_ram #(
   parameter int DEPTH  = 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic mem_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/w6ps_ctrl.sv -----
// ----------------------------------------------------------------------------
// w6ps_ctrl
// Sequencer for table fill, sieve walk, query lookup and result hand-off.
// ----------------------------------------------------------------------------
module w6ps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  logic                  rsp_tready,
   input  w6ps_pkg::w6ps_sts_type sts,
   output w6ps_pkg::w6ps_cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_FILL       = 9'b000000010,
      ST_OUTER_RD   = 9'b000000100,
      ST_OUTER_CHK  = 9'b000001000,
      ST_STRIKE     = 9'b000010000,
      ST_OUTER_NEXT = 9'b000100000,
      ST_Q_MUL      = 9'b001000000,
      ST_Q_RD       = 9'b010000000,
      ST_RESP       = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (req_tuser == w6ps_pkg::KIND_QUERY) begin
                  state_in = ST_Q_MUL;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (sts.outer_last) begin
               cmd.outer_first = 1'b1;
               state_in        = ST_OUTER_RD;
            end else begin
               cmd.outer_inc = 1'b1;
            end
         end
         ST_OUTER_RD: begin
            cmd.rd_outer = 1'b1;
            state_in     = ST_OUTER_CHK;
         end
         ST_OUTER_CHK: begin
            if (sts.rd_minus) begin
               cmd.walk_init  = 1'b1;
               cmd.walk_minus = 1'b1;
               state_in       = ST_STRIKE;
            end else if (sts.rd_plus) begin
               cmd.walk_init = 1'b1;
               state_in      = ST_STRIKE;
            end else begin
               state_in = ST_OUTER_NEXT;
            end
         end
         ST_STRIKE: begin
            if (!sts.walk_end) begin
               cmd.strike = 1'b1;
            end else if (sts.more_plus) begin
               cmd.walk_init = 1'b1;
            end else begin
               state_in = ST_OUTER_NEXT;
            end
         end
         ST_OUTER_NEXT: begin
            if (sts.outer_last) begin
               cmd.set_built = 1'b1;
               state_in      = ST_RESP;
            end else begin
               cmd.outer_inc = 1'b1;
               state_in      = ST_OUTER_RD;
            end
         end
         ST_Q_MUL: begin
            cmd.q_mul = 1'b1;
            state_in  = ST_Q_RD;
         end
         ST_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!sts.out_busy || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!sts.out_busy || rsp_tready))
      else $error("result loaded over an untaken beat");

   a_strike_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.strike |-> !sts.walk_end)
      else $error("strike past table end");

   a_query_path: assert property (@(posedge clock) disable iff (reset)
      cmd.q_mul |=> (state_ff == ST_Q_RD) ##1 (state_ff == ST_RESP))
      else $error("query path out of order");
`endif

endmodule

// ----- hdl/w6ps_dp.sv -----
// ----------------------------------------------------------------------------
// w6ps_dp
// Flag memories, sieve walk counters, query decode and result register.
// ----------------------------------------------------------------------------
module w6ps_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tuser,
   input  logic [15:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   input  w6ps_pkg::w6ps_cmd_type cmd,
   output w6ps_pkg::w6ps_sts_type sts
);

   localparam int IDX_W  = w6ps_pkg::IDX_W;
   localparam int WALK_W = w6ps_pkg::WALK_W;
   localparam int NUM_W  = w6ps_pkg::NUM_W;
   localparam int QUOT_W = w6ps_pkg::QUOT_W;
   localparam int PROD_W = w6ps_pkg::PROD_W;

   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_MINUS = 2'd1,
      CLS_PLUS  = 2'd2
   } cls_type;

   logic [NUM_W-1:0]  number_ff;
   logic              kind_ff;
   logic [IDX_W-1:0]  outer_ff;
   logic [PROD_W-1:0] prod_ff;
   cls_type           cls_ff;
   cls_type           cls_in;
   logic [IDX_W-1:0]  qaddr_ff;
   logic [IDX_W-1:0]  qaddr_in;
   logic              special_ff;
   logic              built_ff;
   logic              flag_p_ff;
   logic              form_minus_ff;
   logic [WALK_W-1:0] wm_ff;
   logic [WALK_W-1:0] wp_ff;
   logic [WALK_W-1:0] stride_ff;
   logic [WALK_W-1:0] i5;
   logic [WALK_W-1:0] i6;
   logic [WALK_W-1:0] i7;
   logic              rsp_valid_ff;
   logic              rsp_flag_ff;
   logic              rsp_built_ff;

   logic [QUOT_W-1:0] quot;
   logic [NUM_W-1:0]  six_q;
   logic [2:0]        rem;
   logic [QUOT_W:0]   key;
   logic              key_in_range;
   logic              wp_in_range;
   logic              qsel;
   logic              qflag;

   logic              m_wr_en, p_wr_en, m_wr_data, p_wr_data;
   logic [IDX_W-1:0]  m_wr_addr, p_wr_addr, rd_addr;
   logic              rd_en, m_rd_data, p_rd_data;

   // query decode: quotient by reciprocal, remainder by subtract
   assign quot  = prod_ff[w6ps_pkg::RECIP_SHIFT +: QUOT_W];
   assign six_q = (NUM_W'(quot) << 2) + (NUM_W'(quot) << 1);
   assign rem   = 3'(number_ff - six_q);

   always_comb begin
      key    = {1'b0, quot};
      cls_in = CLS_NONE;
      if (rem == 3'd5) begin
         key    = {1'b0, quot} + 1'b1;
         cls_in = CLS_MINUS;
      end else if (rem == 3'd1) begin
         cls_in = CLS_PLUS;
      end
      key_in_range = (32'(key) < 32'(w6ps_pkg::TABLE_DEPTH));
      if (!key_in_range) begin
         cls_in = CLS_NONE;
      end
      qaddr_in = IDX_W'(key);
   end

   assign i5 = (WALK_W'(outer_ff) << 2) + WALK_W'(outer_ff);
   assign i6 = (WALK_W'(outer_ff) << 2) + (WALK_W'(outer_ff) << 1);
   assign i7 = (WALK_W'(outer_ff) << 3) - WALK_W'(outer_ff);

   assign wp_in_range = (wp_ff < WALK_W'(w6ps_pkg::TABLE_DEPTH));

   always_comb begin
      m_wr_en   = 1'b0;
      p_wr_en   = 1'b0;
      m_wr_addr = outer_ff;
      p_wr_addr = outer_ff;
      m_wr_data = (outer_ff != '0);
      p_wr_data = (outer_ff != '0);
      if (cmd.fill_write) begin
         m_wr_en = 1'b1;
         p_wr_en = 1'b1;
      end else if (cmd.strike) begin
         m_wr_data = 1'b0;
         p_wr_data = 1'b0;
         if (form_minus_ff) begin
            p_wr_en   = 1'b1;
            p_wr_addr = IDX_W'(wm_ff);
            m_wr_en   = wp_in_range;
            m_wr_addr = IDX_W'(wp_ff);
         end else begin
            m_wr_en   = 1'b1;
            m_wr_addr = IDX_W'(wm_ff);
            p_wr_en   = wp_in_range;
            p_wr_addr = IDX_W'(wp_ff);
         end
      end
   end

   assign rd_en   = cmd.rd_outer | cmd.q_rd;
   assign rd_addr = cmd.q_rd ? qaddr_in : outer_ff;

   w6ps_ram #(.DEPTH(w6ps_pkg::TABLE_DEPTH), .ADDR_W(IDX_W)) u_minus_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (m_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (m_rd_data)
   );

   w6ps_ram #(.DEPTH(w6ps_pkg::TABLE_DEPTH), .ADDR_W(IDX_W)) u_plus_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (p_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_tuser;
         number_ff <= req_tdata[NUM_W-1:0];
      end
      if (cmd.capture) begin
         outer_ff <= '0;
      end else if (cmd.outer_first) begin
         outer_ff <= IDX_W'(1);
      end else if (cmd.outer_inc) begin
         outer_ff <= outer_ff + 1'b1;
      end
      if (cmd.q_mul) begin
         prod_ff <= PROD_W'(number_ff) * PROD_W'(w6ps_pkg::RECIP_SIX);
      end
      if (cmd.q_rd) begin
         cls_ff     <= cls_in;
         qaddr_ff   <= qaddr_in;
         special_ff <= (number_ff == NUM_W'(2)) || (number_ff == NUM_W'(3));
      end
      if (cmd.walk_init && cmd.walk_minus) begin
         flag_p_ff <= p_rd_data;
      end
      if (cmd.walk_init) begin
         form_minus_ff <= cmd.walk_minus;
         if (cmd.walk_minus) begin
            wm_ff     <= i5 - 1'b1;
            wp_ff     <= i7 - 1'b1;
            stride_ff <= i6 - 1'b1;
         end else begin
            wm_ff     <= i5 + 1'b1;
            wp_ff     <= i7 + 1'b1;
            stride_ff <= i6 + 1'b1;
         end
      end else if (cmd.strike) begin
         wm_ff <= wm_ff + stride_ff;
         wp_ff <= wp_ff + stride_ff;
      end
   end

   always_comb begin
      case (cls_ff)
         CLS_MINUS: qsel = m_rd_data;
         CLS_PLUS:  qsel = p_rd_data;
         default:   qsel = 1'b0;
      endcase
   end

   assign qflag = special_ff | (built_ff & qsel);

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_built) begin
            built_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_flag_ff  <= (kind_ff == w6ps_pkg::KIND_QUERY) & qflag;
         rsp_built_ff <= built_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_built_ff, rsp_flag_ff};

   assign sts.kind_query = (kind_ff == w6ps_pkg::KIND_QUERY);
   assign sts.outer_last = (outer_ff == IDX_W'(w6ps_pkg::TABLE_DEPTH - 1));
   assign sts.rd_minus   = m_rd_data;
   assign sts.rd_plus    = p_rd_data;
   assign sts.walk_end   = (wm_ff >= WALK_W'(w6ps_pkg::TABLE_DEPTH));
   assign sts.more_plus  = form_minus_ff & flag_p_ff;
   assign sts.out_busy   = rsp_valid_ff;

`ifndef SYNTHESIS
   a_fill_then_built: assert property (@(posedge clock) disable iff (reset)
      cmd.set_built |=> built_ff)
      else $error("table not marked built");

   a_qaddr_hold: assert property (@(posedge clock) disable iff (reset)
      (cls_ff != CLS_NONE && !cmd.q_rd) |=> $stable(qaddr_ff) || $past(cmd.q_rd))
      else $error("query address moved");
`endif

endmodule

// ----- dv/wheel6_prime_sieve_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel6_prime_sieve_tb
// Self-checking bench for the wheel prime sieve. Build and query beats go in on
// the request stream. A behavioral sieve kept in the bench predicts each answer,
// and every response beat is compared in order against it. Traffic runs under
// random idling on both sides, a long response stall and a full drain pause.
// ----------------------------------------------------------------------------
module wheel6_prime_sieve_tb;

   localparam int NUM_W       = w6ps_pkg::NUM_W;
   localparam int TABLE_DEPTH = w6ps_pkg::TABLE_DEPTH;

   typedef struct {
      w6ps_pkg::w6ps_kind_type kind;
      logic [NUM_W-1:0]        number;
      logic                    prime_flag;
      logic                    table_ready;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [13:0] number, [15:14] zero
   logic        req_tuser;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] prime_flag, [1] table_ready, [7:2] zero

   answer_type pending_answers[$];
   bit [1:0]   sieve_flags [TABLE_DEPTH];
   bit         table_built = 1'b0;
   int         error_count = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   int         hold_cycles = 0;

   wheel6_prime_sieve DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clear flags of the products of 6i-1 (minus_form) or 6i+1 with every 6p+-1
   function automatic void strike_products(input int unsigned i, input bit minus_form);
      int unsigned lo_idx;
      int unsigned hi_idx;
      for (int unsigned p = 1; p < TABLE_DEPTH; p++) begin
         if (minus_form) begin
            lo_idx = 6 * i * p - i - p;
            hi_idx = 6 * i * p + i - p;
            if (lo_idx >= TABLE_DEPTH) break;
            sieve_flags[lo_idx][1] = 1'b0;
            if (hi_idx < TABLE_DEPTH) sieve_flags[hi_idx][0] = 1'b0;
         end else begin
            lo_idx = 6 * i * p - i + p;
            hi_idx = 6 * i * p + i + p;
            if (lo_idx >= TABLE_DEPTH) break;
            sieve_flags[lo_idx][0] = 1'b0;
            if (hi_idx < TABLE_DEPTH) sieve_flags[hi_idx][1] = 1'b0;
         end
      end
   endfunction

   function automatic void rebuild_sieve();
      sieve_flags[0] = 2'b00;
      for (int unsigned k = 1; k < TABLE_DEPTH; k++) sieve_flags[k] = 2'b11;
      for (int unsigned k = 1; k < TABLE_DEPTH; k++) begin
         if (sieve_flags[k][0]) strike_products(k, 1'b1);
         if (sieve_flags[k][1]) strike_products(k, 1'b0);
      end
      table_built = 1'b1;
   endfunction

   function automatic logic predict_prime(input logic [NUM_W-1:0] number);
      int unsigned n;
      int unsigned k;
      n = number;
      if (n == 2 || n == 3) return 1'b1;
      if ((n + 1) % 6 == 0) begin
         k = (n + 1) / 6;
         return (k < TABLE_DEPTH) ? sieve_flags[k][0] : 1'b0;
      end
      if (n % 6 == 1) begin
         k = (n - 1) / 6;
         return (k < TABLE_DEPTH) ? sieve_flags[k][1] : 1'b0;
      end
      return 1'b0;
   endfunction

   // mostly 6k+-1 candidates, some small values, the rest uniform
   function automatic logic [NUM_W-1:0] random_number();
      int unsigned pick;
      int unsigned k;
      int unsigned n;
      pick = $urandom_range(0, 9);
      k    = $urandom_range(1, TABLE_DEPTH - 2);
      if (pick < 5) n = ($urandom_range(0, 1) != 0) ? 6 * k + 1 : 6 * k - 1;
      else if (pick < 6) n = $urandom_range(0, 40);
      else n = $urandom_range(0, (1 << NUM_W) - 1);
      return NUM_W'(n);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_answer(input logic [7:0] data);
      answer_type ans;
      if (pending_answers.size() == 0) begin
         report_mismatch($sformatf("response beat %h with no answer pending", data));
         return;
      end
      ans = pending_answers.pop_front();
      if (data[0] !== ans.prime_flag)
         report_mismatch($sformatf("%s %0d: prime_flag %b, predicted %b",
                                   ans.kind.name(), ans.number, data[0], ans.prime_flag));
      if (data[1] !== ans.table_ready)
         report_mismatch($sformatf("%s %0d: table_ready %b, predicted %b",
                                   ans.kind.name(), ans.number, data[1], ans.table_ready));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_answer(rsp_tdata);
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic send_beat(input w6ps_pkg::w6ps_kind_type kind,
                            input logic [NUM_W-1:0] number);
      answer_type ans;
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, number};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ans.kind   = kind;
      ans.number = number;
      if (kind == w6ps_pkg::KIND_BUILD) begin
         rebuild_sieve();
         ans.prime_flag = 1'b0;
      end else begin
         ans.prime_flag = predict_prime(number);
      end
      ans.table_ready = table_built;
      pending_answers.push_back(ans);
   endtask

   // hold the request side until every pending answer is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_query_before_build();
      int unsigned probes[$] = {0, 1, 2, 3, 5, 25, 16381};
      foreach (probes[j]) send_beat(w6ps_pkg::KIND_QUERY, NUM_W'(probes[j]));
   endtask

   task automatic test_first_build();
      int unsigned probes[$] = {0, 1, 2, 3, 4, 5, 25, 35, 49, 16381, 16383};
      send_beat(w6ps_pkg::KIND_BUILD, '0);
      foreach (probes[j]) send_beat(w6ps_pkg::KIND_QUERY, NUM_W'(probes[j]));
   endtask

   task automatic test_repeated_build();
      int unsigned probes[$] = {5, 25, 16381};
      send_beat(w6ps_pkg::KIND_BUILD, '1);
      foreach (probes[j]) send_beat(w6ps_pkg::KIND_QUERY, NUM_W'(probes[j]));
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 119) == 0) send_beat(w6ps_pkg::KIND_BUILD, NUM_W'($urandom));
         else send_beat(w6ps_pkg::KIND_QUERY, random_number());
      end
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0;
      hold_cycles = 300;
      for (int n = 0; n < 40; n++) send_beat(w6ps_pkg::KIND_QUERY, random_number());
      wait_drained();
   endtask

   initial begin
      int waited;
      waited     = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_query_before_build();
      test_first_build();
      test_repeated_build();
      wait_drained();
      test_random_traffic(8, 66, 150);
      test_backpressure();
      test_random_traffic(66, 8, 150);
      test_random_traffic(0, 0, 120);

      req_tvalid <= 1'b0;
      rx_idle_pct = 0;
      @(posedge clock);
      while (pending_answers.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch($sformatf("%0d answers never returned", pending_answers.size()));
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/w6ps_pkg.sv
hdl/w6ps_ram.sv
hdl/w6ps_ctrl.sv
hdl/w6ps_dp.sv
hdl/wheel6_prime_sieve.sv
dv/wheel6_prime_sieve_tb.sv
